### design/pfah_pkg.sv
// Shared constants for the packed add-subtract / horizontal add unit.
package pfah_pkg;

   localparam int DP_EXP_BITS = 11;
   localparam int DP_MAN_BITS = 52;
   localparam int SP_EXP_BITS = 8;
   localparam int SP_MAN_BITS = 23;

   localparam int REQ_DATA_BITS = 264;
   localparam int RSP_DATA_BITS = 128;

   localparam logic [2:0] CMD_ADDSUB_PD = 3'd0;
   localparam logic [2:0] CMD_ADDSUB_PS = 3'd1;
   localparam logic [2:0] CMD_HADD_PD   = 3'd2;
   localparam logic [2:0] CMD_HADD_PS   = 3'd3;
   localparam logic [2:0] CMD_HSUB_PD   = 3'd4;
   localparam logic [2:0] CMD_HSUB_PS   = 3'd5;

endpackage

### design/packed_float_addsub_hadd_unit_core.sv
// Top level of the packed add-subtract / horizontal add / horizontal subtract unit.
//
//  channel | dir | handshake             | contents
//  req     | in  | req_tvalid/req_tready | command, dst_lo, dst_hi, src_lo, src_hi
//  rsp     | out | rsp_tvalid/rsp_tready | res_lo, res_hi
//
//  rsp_tvalid is the last of four valid bits that follow each request through the
//  four-stage adder lanes (swap, align, add, round); one request enters per cycle
//  unless a stalled result holds the pipeline.
//  Reset clears the stage valid bits only; lane data registers are not reset.
//  A stalled result holds the whole pipeline in place; req_tready drops in the
//  same cycle, so nothing is lost or repeated.
module packed_float_addsub_hadd_unit_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // command[2:0], dst_lo[66:3], dst_hi[130:67], src_lo[194:131], src_hi[258:195]
   input  logic [pfah_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // res_lo[63:0], res_hi[127:64]
   output logic [pfah_pkg::RSP_DATA_BITS-1:0]  rsp_tdata
);
   import pfah_pkg::*;

   logic [2:0]  command;
   logic [63:0] dst_lo, dst_hi, src_lo, src_hi;
   logic        advance;

   assign command = req_tdata[2:0];
   assign dst_lo  = req_tdata[66:3];
   assign dst_hi  = req_tdata[130:67];
   assign src_lo  = req_tdata[194:131];
   assign src_hi  = req_tdata[258:195];

   // advance every stage unless the finished result is stuck
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   // decode the command
   logic is_addsub, is_hsub, is_ps, is_bad;
   always_comb begin
      is_addsub = 1'b0;
      is_hsub   = 1'b0;
      is_ps     = 1'b0;
      is_bad    = 1'b0;
      case (command)
         CMD_ADDSUB_PD: is_addsub = 1'b1;
         CMD_ADDSUB_PS: begin
            is_addsub = 1'b1;
            is_ps     = 1'b1;
         end
         CMD_HADD_PD:   is_addsub = 1'b0;
         CMD_HADD_PS:   is_ps     = 1'b1;
         CMD_HSUB_PD:   is_hsub   = 1'b1;
         CMD_HSUB_PS: begin
            is_hsub = 1'b1;
            is_ps   = 1'b1;
         end
         default:       is_bad    = 1'b1;
      endcase
   end

   // route operands for the double lanes
   logic [63:0] da0, db0, da1, db1;
   logic        dsub0, dsub1;
   always_comb begin
      if (is_addsub) begin
         da0 = dst_lo; db0 = src_lo; dsub0 = 1'b1;
         da1 = dst_hi; db1 = src_hi; dsub1 = 1'b0;
      end else begin
         da0 = dst_lo; db0 = dst_hi; dsub0 = is_hsub;
         da1 = src_lo; db1 = src_hi; dsub1 = is_hsub;
      end
   end

   // route operands for the single lanes
   logic [31:0] d_w [4];
   logic [31:0] s_w [4];
   logic [31:0] sa_w [4];
   logic [31:0] sb_w [4];
   logic [3:0]  ssub;
   always_comb begin
      d_w[0] = dst_lo[31:0]; d_w[1] = dst_lo[63:32];
      d_w[2] = dst_hi[31:0]; d_w[3] = dst_hi[63:32];
      s_w[0] = src_lo[31:0]; s_w[1] = src_lo[63:32];
      s_w[2] = src_hi[31:0]; s_w[3] = src_hi[63:32];
      if (is_addsub) begin
         for (int k = 0; k < 4; k++) begin
            sa_w[k] = d_w[k];
            sb_w[k] = s_w[k];
            ssub[k] = (k % 2 == 0);
         end
      end else begin
         sa_w[0] = d_w[0]; sb_w[0] = d_w[1];
         sa_w[1] = d_w[2]; sb_w[1] = d_w[3];
         sa_w[2] = s_w[0]; sb_w[2] = s_w[1];
         sa_w[3] = s_w[2]; sb_w[3] = s_w[3];
         ssub    = {4{is_hsub}};
      end
   end

   logic [63:0] dy [2];
   logic [31:0] sy [4];

   pfah_fp_add #(.EB(DP_EXP_BITS), .MB(DP_MAN_BITS)) u_dp0 (
      .clock(clock), .enable(advance), .a(da0), .b(db0), .sub(dsub0), .y(dy[0])
   );
   pfah_fp_add #(.EB(DP_EXP_BITS), .MB(DP_MAN_BITS)) u_dp1 (
      .clock(clock), .enable(advance), .a(da1), .b(db1), .sub(dsub1), .y(dy[1])
   );

   for (genvar g = 0; g < 4; g++) begin : g_sp
      pfah_fp_add #(.EB(SP_EXP_BITS), .MB(SP_MAN_BITS)) u_sp (
         .clock(clock), .enable(advance), .a(sa_w[g]), .b(sb_w[g]),
         .sub(ssub[g]), .y(sy[g])
      );
   end

   // valid bits, lane-format tags and bad-command flags travel alongside the adder stages
   logic [3:0] valid_ff, valid_in;
   logic [3:0] ps_ff, ps_in;
   logic [3:0] bad_ff, bad_in;

   always_comb begin
      valid_in = {valid_ff[2:0], req_tvalid};
      ps_in    = {ps_ff[2:0], is_ps};
      bad_in   = {bad_ff[2:0], is_bad};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ps_ff  <= ps_in;
         bad_ff <= bad_in;
      end
   end

   assign rsp_tvalid = valid_ff[3];

   always_comb begin
      if (bad_ff[3]) begin
         rsp_tdata = '0;
      end else if (ps_ff[3]) begin
         rsp_tdata = {sy[3], sy[2], sy[1], sy[0]};
      end else begin
         rsp_tdata = {dy[1], dy[0]};
      end
   end

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request taken while result stalled");

   a_enter: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> valid_ff[0])
      else $error("accepted request lost at stage one");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && bad_ff[3] |-> rsp_tdata == '0)
      else $error("unknown command gave nonzero result");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(valid_ff))
      else $error("pipeline moved while stalled");

endmodule

### design/pfah_fp_add.sv
// Four-stage IEEE add/subtract lane: swap, align, add, normalize and round.
module pfah_fp_add #(
   parameter int EB = pfah_pkg::DP_EXP_BITS,
   parameter int MB = pfah_pkg::DP_MAN_BITS
) (
   input  logic             clock,
   input  logic             enable,
   input  logic [EB+MB:0]   a,
   input  logic [EB+MB:0]   b,
   input  logic             sub,
   output logic [EB+MB:0]   y
);
   import pfah_pkg::*;

   localparam int W  = EB + MB + 1;
   localparam int MW = MB + 4;
   localparam int SW = MB + 5;
   localparam int LW = $clog2(SW + 1);
   localparam int XW = EB + LW;
   localparam logic [EB-1:0] EMAX = {EB{1'b1}};

   // stage 1: specials, swap
   logic [EB-1:0] ea, eb;
   logic [MB-1:0] fa, fb;
   logic          sa, sbx, a_zero, b_zero, swp;
   logic [W-1:0]  bx, spec_val;
   logic          spec;
   logic [MW-1:0] ma, mb;
   logic [EB-1:0] xa, xb;

   logic          spec1_ff, sign1_ff, esub1_ff;
   logic [W-1:0]  sval1_ff;
   logic [MW-1:0] ma1_ff, mb1_ff;
   logic [EB-1:0] e1_ff, d1_ff;

   always_comb begin
      ea     = a[W-2:MB];
      eb     = b[W-2:MB];
      fa     = a[MB-1:0];
      fb     = b[MB-1:0];
      sa     = a[W-1];
      sbx    = b[W-1] ^ sub;
      bx     = {sbx, b[W-2:0]};
      a_zero = (ea == '0) && (fa == '0);
      b_zero = (eb == '0) && (fb == '0);
      spec     = 1'b1;
      spec_val = a;
      if ((ea == EMAX) && (fa != '0)) begin
         spec_val = a | (W'(1) << (MB - 1));
      end else if ((eb == EMAX) && (fb != '0)) begin
         spec_val = b | (W'(1) << (MB - 1));
      end else if (ea == EMAX) begin
         if ((eb == EMAX) && (sa != sbx)) begin
            spec_val = {1'b1, EMAX, 1'b1, {(MB-1){1'b0}}};
         end else begin
            spec_val = a;
         end
      end else if (eb == EMAX) begin
         spec_val = bx;
      end else if (a_zero) begin
         if (b_zero) begin
            spec_val = (sa == sbx) ? a : '0;
         end else begin
            spec_val = bx;
         end
      end else if (b_zero) begin
         spec_val = a;
      end else begin
         spec = 1'b0;
      end
      ma  = {(ea != '0), fa, 3'b000};
      mb  = {(eb != '0), fb, 3'b000};
      xa  = (ea != '0) ? ea : EB'(1);
      xb  = (eb != '0) ? eb : EB'(1);
      swp = (xb > xa) || ((xb == xa) && (mb > ma));
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         spec1_ff <= spec;
         sval1_ff <= spec_val;
         sign1_ff <= swp ? sbx : sa;
         esub1_ff <= sa ^ sbx;
         ma1_ff   <= swp ? mb : ma;
         mb1_ff   <= swp ? ma : mb;
         e1_ff    <= swp ? xb : xa;
         d1_ff    <= swp ? (xb - xa) : (xa - xb);
      end
   end

   // stage 2: align the smaller operand, keep a sticky bit
   logic          spec2_ff, sign2_ff, esub2_ff;
   logic [W-1:0]  sval2_ff;
   logic [MW-1:0] ma2_ff, mb2_ff, mb_al;
   logic [EB-1:0] e2_ff;

   always_comb begin
      mb_al = (mb1_ff >> d1_ff);
      mb_al[0] = mb_al[0] | (|(mb1_ff & ~({MW{1'b1}} << d1_ff)));
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         spec2_ff <= spec1_ff;
         sval2_ff <= sval1_ff;
         sign2_ff <= sign1_ff;
         esub2_ff <= esub1_ff;
         ma2_ff   <= ma1_ff;
         mb2_ff   <= mb_al;
         e2_ff    <= e1_ff;
      end
   end

   // stage 3: add magnitudes, count leading zeros
   logic [SW-1:0] sum;
   logic [LW-1:0] lz;
   logic          found;
   logic          spec3_ff, sign3_ff;
   logic [W-1:0]  sval3_ff;
   logic [SW-1:0] m3_ff;
   logic [EB-1:0] e3_ff;
   logic [LW-1:0] lz3_ff;

   always_comb begin
      sum = esub2_ff ? ({1'b0, ma2_ff} - {1'b0, mb2_ff})
                     : ({1'b0, ma2_ff} + {1'b0, mb2_ff});
      lz    = LW'(SW);
      found = 1'b0;
      for (int i = SW - 1; i >= 0; i--) begin
         if (!found && sum[i]) begin
            lz    = LW'(SW - 1 - i);
            found = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         spec3_ff <= spec2_ff;
         sval3_ff <= sval2_ff;
         sign3_ff <= sign2_ff;
         m3_ff    <= sum;
         e3_ff    <= e2_ff;
         lz3_ff   <= lz;
      end
   end

   // stage 4: normalize, round to nearest even, pack
   logic [SW-1:0] mn;
   logic [XW-1:0] en, lim, shv, e_fin, expf;
   logic [MB+1:0] mr;
   logic          rnd;
   logic [W-1:0]  res;
   logic [W-1:0]  y_ff;

   always_comb begin
      lim = XW'(e3_ff) - XW'(1);
      shv = XW'(lz3_ff) - XW'(1);
      if (m3_ff[SW-1]) begin
         mn = (m3_ff >> 1) | SW'(m3_ff[0]);
         en = XW'(e3_ff) + XW'(1);
      end else begin
         if (shv > lim) begin
            shv = lim;
         end
         mn = m3_ff << shv;
         en = XW'(e3_ff) - shv;
      end
      rnd = mn[2] && (mn[1] || mn[0] || mn[3]);
      mr  = {1'b0, mn[MB+3:3]} + (MB+2)'(rnd);
      e_fin = en;
      if (mr[MB+1]) begin
         mr    = mr >> 1;
         e_fin = en + XW'(1);
      end
      expf = mr[MB] ? e_fin : '0;
      if (spec3_ff) begin
         res = sval3_ff;
      end else if (m3_ff == '0) begin
         res = '0;
      end else if (expf >= XW'(EMAX)) begin
         res = {sign3_ff, EMAX, {MB{1'b0}}};
      end else begin
         res = {sign3_ff, expf[EB-1:0], mr[MB-1:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         y_ff <= res;
      end
   end

   assign y = y_ff;

endmodule

### bench/testbench.sv
// Self-checking bench for the packed add-subtract / horizontal add / horizontal subtract unit.
module testbench;
   import pfah_pkg::*;

   // Command codes the package leaves undefined; the unit must return zero for them.
   localparam logic [2:0] CMD_RSVD_6 = 3'd6;
   localparam logic [2:0] CMD_RSVD_7 = 3'd7;

   typedef struct packed {
      logic [63:0] res_hi;
      logic [63:0] res_lo;
   } packed_result_type;

   // Scoreboard: predicts each accepted request and checks results in order.
   class addsub_scoreboard_type;
      packed_result_type pending_results[$];
      int mismatches = 0;
      int requests = 0;
      int responses = 0;
      int cmd_seen[8];

      // Round-to-nearest-even add or subtract of one lane; ew/mw select the format.
      static function automatic logic [63:0] lane_add(logic [63:0] a, logic [63:0] b,
                                                      bit sub, int ew, int mw);
         logic [63:0] signbit, emax, fmask, qbit, hid;
         logic [63:0] ea, eb, fa, fb, ma, mbv, m, t, lost, expf;
         bit sa, sb, swp, rnd;
         longint e, exa, exb, d;
         signbit = 64'd1 << (ew + mw);
         emax = (64'd1 << ew) - 1;
         fmask = (64'd1 << mw) - 1;
         qbit = 64'd1 << (mw - 1);
         hid = 64'd1 << mw;
         ea = (a >> mw) & emax;
         eb = (b >> mw) & emax;
         fa = a & fmask;
         fb = b & fmask;
         if (ea == emax && fa != 0) return a | qbit;
         if (eb == emax && fb != 0) return b | qbit;
         if (sub) b = b ^ signbit;
         sa = (a & signbit) != 0;
         sb = (b & signbit) != 0;
         if (ea == emax) begin
            if (eb == emax && sa != sb) return signbit | (emax << mw) | qbit;
            return a;
         end
         if (eb == emax) return b;
         if (ea == 0 && fa == 0) begin
            if (eb == 0 && fb == 0) return (sa == sb) ? a : 64'd0;
            return b;
         end
         if (eb == 0 && fb == 0) return a;
         ma = ((ea != 0) ? (fa | hid) : fa) << 3;
         mbv = ((eb != 0) ? (fb | hid) : fb) << 3;
         exa = (ea != 0) ? longint'(ea) : 1;
         exb = (eb != 0) ? longint'(eb) : 1;
         swp = (exb > exa) || (exb == exa && mbv > ma);
         if (swp) begin
            t = ma; ma = mbv; mbv = t;
            d = exa; exa = exb; exb = d;
            sa = sb;
            sb = (a & signbit) != 0;
         end
         d = exa - exb;
         if (d > mw + 4) begin
            mbv = (mbv != 0) ? 64'd1 : 64'd0;
         end else if (d > 0) begin
            lost = mbv & ((64'd1 << d) - 1);
            mbv = (mbv >> d) | ((lost != 0) ? 64'd1 : 64'd0);
         end
         m = (sa == sb) ? ma + mbv : ma - mbv;
         if (m == 0) return 64'd0;
         e = exa;
         if (m >= (64'd1 << (mw + 4))) begin
            m = (m >> 1) | (m & 64'd1);
            e++;
         end else begin
            while (m < (64'd1 << (mw + 3)) && e > 1) begin
               m = m << 1;
               e--;
            end
         end
         rnd = (m[2:0] > 3'd4) || (m[2:0] == 3'd4 && m[3]);
         m = m >> 3;
         if (rnd) m++;
         if (m >= (64'd1 << (mw + 1))) begin
            m = m >> 1;
            e++;
         end
         expf = ((m & hid) != 0) ? 64'(e) : 64'd0;
         if (expf >= emax) return (sa ? signbit : 64'd0) | (emax << mw);
         return (sa ? signbit : 64'd0) | (expf << mw) | (m & fmask);
      endfunction

      static function automatic logic [63:0] dp(logic [63:0] a, logic [63:0] b, bit sub);
         return lane_add(a, b, sub, DP_EXP_BITS, DP_MAN_BITS);
      endfunction

      static function automatic logic [31:0] sp(logic [31:0] a, logic [31:0] b, bit sub);
         logic [63:0] r;
         r = lane_add({32'd0, a}, {32'd0, b}, sub, SP_EXP_BITS, SP_MAN_BITS);
         return r[31:0];
      endfunction

      static function automatic packed_result_type compute(logic [2:0] cmd, logic [63:0] dl,
            logic [63:0] dh, logic [63:0] sl, logic [63:0] sh);
         packed_result_type r;
         bit hsub;
         r = '0;
         hsub = (cmd == CMD_HSUB_PD || cmd == CMD_HSUB_PS);
         case (cmd)
            CMD_ADDSUB_PD: begin
               r.res_lo = dp(dl, sl, 1'b1);
               r.res_hi = dp(dh, sh, 1'b0);
            end
            CMD_ADDSUB_PS: begin
               r.res_lo = {sp(dl[63:32], sl[63:32], 1'b0), sp(dl[31:0], sl[31:0], 1'b1)};
               r.res_hi = {sp(dh[63:32], sh[63:32], 1'b0), sp(dh[31:0], sh[31:0], 1'b1)};
            end
            CMD_HADD_PD, CMD_HSUB_PD: begin
               r.res_lo = dp(dl, dh, hsub);
               r.res_hi = dp(sl, sh, hsub);
            end
            CMD_HADD_PS, CMD_HSUB_PS: begin
               r.res_lo = {sp(dh[31:0], dh[63:32], hsub), sp(dl[31:0], dl[63:32], hsub)};
               r.res_hi = {sp(sh[31:0], sh[63:32], hsub), sp(sl[31:0], sl[63:32], hsub)};
            end
            default: r = '0;
         endcase
         return r;
      endfunction

      function void note_request(logic [REQ_DATA_BITS-1:0] data);
         pending_results.push_back(compute(data[2:0], data[66:3], data[130:67],
                                           data[194:131], data[258:195]));
         cmd_seen[data[2:0]]++;
         requests++;
      endfunction

      function void check_result(logic [RSP_DATA_BITS-1:0] data);
         packed_result_type want;
         responses++;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("ERROR: result %h arrived with none expected", data);
            return;
         end
         want = pending_results.pop_front();
         if (data[63:0] !== want.res_lo || data[127:64] !== want.res_hi) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: result %0d: res_lo exp %h got %h, res_hi exp %h got %h",
                        responses, want.res_lo, data[63:0], want.res_hi, data[127:64]);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;

   addsub_scoreboard_type board = new();
   bit hold_off_request = 1'b0;   // sender asks the receiver for one long stall
   bit no_idle = 1'b0;            // stretch with neither side idling

   packed_float_addsub_hadd_unit_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watch both handshakes at the edge; values sampled here are the pre-edge ones.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) board.note_request(req_tdata);
         if (rsp_tvalid && rsp_tready) board.check_result(rsp_tdata);
      end
   end

   // Mostly short gaps, now and then a long one.
   function automatic int idle_cycles();
      int p;
      p = $urandom_range(0, 99);
      if (no_idle) return 0;
      if (p < 55) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Interesting lane values: signed zeros, infinities, NaNs, denormals, extremes.
   function automatic logic [63:0] pick_dp();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 15))
         0: v = {v[63], 63'd0};
         1: v = {v[63], 11'h7ff, 52'd0};
         2: v = {v[63], 11'h7ff, v[51:0] | 52'd1};
         3: v = {v[63], 11'd0, v[51:0]};
         4: v = {v[63], 11'h7fe, v[51:0]};
         5: v = {v[63], 11'd1, v[51:0]};
         6: v = {v[63], 11'($urandom_range(1000, 1046)), v[51:0]};
         default: ;
      endcase
      return v;
   endfunction

   function automatic logic [31:0] pick_sp();
      logic [31:0] v;
      v = $urandom;
      case ($urandom_range(0, 15))
         0: v = {v[31], 31'd0};
         1: v = {v[31], 8'hff, 23'd0};
         2: v = {v[31], 8'hff, v[22:0] | 23'd1};
         3: v = {v[31], 8'd0, v[22:0]};
         4: v = {v[31], 8'hfe, v[22:0]};
         5: v = {v[31], 8'd1, v[22:0]};
         6: v = {v[31], 8'($urandom_range(120, 134)), v[22:0]};
         default: ;
      endcase
      return v;
   endfunction

   // Near a given value: same or flipped sign, a few ulps off, to force cancellation.
   function automatic logic [63:0] nudge(logic [63:0] v, bit single);
      logic [63:0] r;
      r = v + $urandom_range(0, 3) - $urandom_range(0, 3);
      if ($urandom_range(0, 1)) r = r ^ (single ? 64'h8000_0000 : 64'h8000_0000_0000_0000);
      return r;
   endfunction

   task automatic send(logic [2:0] cmd, logic [63:0] dl, logic [63:0] dh,
                       logic [63:0] sl, logic [63:0] sh);
      int gap;
      gap = idle_cycles();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {5'd0, sh, sl, dh, dl, cmd};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_random();
      logic [2:0] cmd;
      logic [63:0] w[4];
      logic [63:0] n_hi, n_lo;
      bit single;
      cmd = ($urandom_range(0, 29) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      single = (cmd == CMD_ADDSUB_PS || cmd == CMD_HADD_PS || cmd == CMD_HSUB_PS);
      foreach (w[i]) w[i] = single ? {pick_sp(), pick_sp()} : pick_dp();
      // Partner lanes close to each other so sums cancel and renormalize.
      if ($urandom_range(0, 3) == 0) begin
         if (cmd == CMD_ADDSUB_PD || cmd == CMD_ADDSUB_PS) begin
            if (single) begin
               n_hi = nudge(w[0] >> 32, 1);
               n_lo = nudge(w[0], 1);
               w[2] = {n_hi[31:0], n_lo[31:0]};
               n_hi = nudge(w[1] >> 32, 1);
               n_lo = nudge(w[1], 1);
               w[3] = {n_hi[31:0], n_lo[31:0]};
            end else begin
               w[2] = nudge(w[0], 0);
               w[3] = nudge(w[1], 0);
            end
         end else if (single) begin
            foreach (w[i]) begin
               n_lo = nudge(w[i], 1);
               w[i][63:32] = n_lo[31:0];
            end
         end else begin
            w[1] = nudge(w[0], 0);
            w[3] = nudge(w[2], 0);
         end
      end
      send(cmd, w[0], w[1], w[2], w[3]);
   endtask

   // Receiver: random stalls, plus one long hold-off when the sender asks for it.
   initial begin : receiver
      int n;
      @(negedge reset);
      forever begin
         if (hold_off_request) begin
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_off_request = 1'b0;
         end
         n = idle_cycles();
         if (n > 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   end

   initial begin : watchdog
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

   initial begin : stimulus
      logic [63:0] dmax, dmin, sdn;
      int wait_cycles;
      dmax = 64'h7fef_ffff_ffff_ffff;
      dmin = 64'h0000_0000_0000_0001;
      sdn = 64'h007f_ffff_0000_0001;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: every command, signed zeros, infinities, NaN ordering,
      // inf minus inf, overflow, denormals, exact cancellation, all-ones bits.
      send(CMD_ADDSUB_PD, 64'h8000_0000_0000_0000, 64'd0, 64'd0, 64'h8000_0000_0000_0000);
      send(CMD_ADDSUB_PD, 64'h7ff0_0000_0000_0000, 64'h7ff0_0000_0000_0000,
           64'h7ff0_0000_0000_0000, 64'hfff0_0000_0000_0000);
      send(CMD_ADDSUB_PD, 64'h7ff0_0000_0000_0001, dmax, 64'hfff8_0000_0000_0002,
           64'h7ff4_0000_0000_0000);
      send(CMD_ADDSUB_PD, {1'b1, dmax[62:0]}, dmax, dmax, dmax);
      send(CMD_ADDSUB_PD, dmin, 64'h000f_ffff_ffff_ffff, dmin, dmin);
      send(CMD_ADDSUB_PD, '1, '1, '1, '1);
      send(CMD_ADDSUB_PD, 64'h3ff0_0000_0000_0000, 64'h3ff0_0000_0000_0000,
           64'h3ff0_0000_0000_0000, 64'hbff0_0000_0000_0000);
      send(CMD_ADDSUB_PD, 64'h3ff0_0000_0000_0000, 64'h4340_0000_0000_0000,
           64'h3ca0_0000_0000_0000, 64'h3ff8_0000_0000_0000);
      send(CMD_ADDSUB_PS, 64'h7f80_0000_ff80_0000, 64'h7f7f_ffff_7fc0_0001,
           64'hff80_0000_ff80_0000, 64'h7f7f_ffff_7fa0_0000);
      send(CMD_ADDSUB_PS, sdn, 64'h8000_0000_0000_0000, sdn, 64'h0000_0000_8000_0000);
      send(CMD_ADDSUB_PS, '1, '0, '0, '1);
      send(CMD_HADD_PD, 64'h7ff0_0000_0000_0000, 64'hfff0_0000_0000_0000, dmax, dmax);
      send(CMD_HADD_PD, dmin, {1'b1, dmin[62:0]}, 64'h8000_0000_0000_0000,
           64'h8000_0000_0000_0000);
      send(CMD_HADD_PS, 64'h7f80_0000_ff80_0000, 64'h7f7f_ffff_7f7f_ffff,
           64'h0000_0001_8000_0001, 64'h3f80_0000_3380_0000);
      send(CMD_HADD_PS, 64'h7fc0_0000_7f80_0001, '1, '0, sdn);
      send(CMD_HSUB_PD, 64'h7ff0_0000_0000_0000, 64'h7ff0_0000_0000_0000, dmax, {1'b1, dmax[62:0]});
      send(CMD_HSUB_PD, 64'h3ff0_0000_0000_0001, 64'h3ff0_0000_0000_0000, '1, 64'h7ff8_0000_0000_0000);
      send(CMD_HSUB_PS, 64'h7f80_0000_7f80_0000, 64'h0000_0000_8000_0000,
           64'hff7f_ffff_7f7f_ffff, sdn);
      send(CMD_HSUB_PS, '1, '0, 64'h3f80_0001_3f80_0000, 64'h7fc0_0000_7f90_0000);
      send(CMD_RSVD_6, '1, '1, '1, '1);
      send(CMD_RSVD_7, 64'h3ff0_0000_0000_0000, dmax, dmin, '1);

      // Random part; one idle-free stretch and one long receiver hold-off.
      for (int i = 0; i < 1200; i++) begin
         no_idle = (i >= 200 && i < 300);
         if (i == 600) hold_off_request = 1'b1;
         send_random();
      end
      req_tvalid <= 1'b0;

      wait_cycles = 0;
      while (board.pending_results.size() != 0 && wait_cycles < 20000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (20) @(posedge clock);

      $display("Ran %0d requests (%0d results checked), all six commands plus reserved codes,",
               board.requests, board.responses);
      $display("with zeros, infinities, NaNs, denormals, overflow and near-cancellation operands.");
      if (board.mismatches == 0 && board.pending_results.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches, %0d results missing", board.mismatches,
                  board.pending_results.size());
         $display("Verification failed");
      end
      $finish;
   end
endmodule

### filelist.f
design/pfah_pkg.sv
design/pfah_fp_add.sv
design/packed_float_addsub_hadd_unit_core.sv
bench/testbench.sv
